### sv/gpio_port_with_pin_interrupts_assert.svh
// ---------------------------------------------------------------------------
// GPIO port assertion macros
// Shared concurrent assertion forms for the GPIO port modules.
// ---------------------------------------------------------------------------
`ifndef GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH
`define GPIO_PORT_WITH_PIN_INTERRUPTS_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define GPIOPI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpio port assertion failed");

// Next-cycle implication, checked out of reset
`define GPIOPI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpio port assertion failed");

`endif

### sv/gpiopi_pkg.sv
// ---------------------------------------------------------------------------
// GPIO port package
// Word types, command and register codes, and pin mask helper.
// ---------------------------------------------------------------------------
package gpiopi_pkg;

  localparam int FieldWidth   = 16;
  localparam int PinCountDflt = 16;

  // Item commands
  typedef enum logic [1:0] {
    CMD_IDLE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  // Register word indexes
  typedef enum logic [3:0] {
    REG_DATA     = 4'd0,
    REG_DATAOUT  = 4'd1,
    REG_OUTENSET = 4'd4,
    REG_OUTENCLR = 4'd5,
    REG_ALTSET   = 4'd6,
    REG_ALTCLR   = 4'd7,
    REG_INTENSET = 4'd8,
    REG_INTENCLR = 4'd9,
    REG_TYPESET  = 4'd10,
    REG_TYPECLR  = 4'd11,
    REG_POLSET   = 4'd12,
    REG_POLCLR   = 4'd13,
    REG_STATUS   = 4'd14
  } reg_addr_e;

  // Input word
  typedef struct packed {
    logic [1:0]            cmd;
    logic [3:0]            addr;
    logic [FieldWidth-1:0] wdata;
    logic [FieldWidth-1:0] pins_in;
  } gpio_in_t;

  // Result word
  typedef struct packed {
    logic [FieldWidth-1:0] rdata;
    logic [FieldWidth-1:0] pins_out;
    logic [FieldWidth-1:0] pins_drive_enable;
    logic [FieldWidth-1:0] alt_select;
    logic                  irq;
  } gpio_out_t;

  // Interrupt controls handed to the detector
  typedef struct packed {
    logic [FieldWidth-1:0] enable;
    logic [FieldWidth-1:0] edge_type;
    logic [FieldWidth-1:0] polarity;
  } irq_ctrl_t;

  // Mask of pins that exist; pins beyond the field width are dropped
  function automatic logic [FieldWidth-1:0] present_pins(input int count);
    int     used;
    logic [63:0] full;
    used = (count > FieldWidth) ? FieldWidth : count;
    full = (64'd1 << used) - 64'd1;
    return full[FieldWidth-1:0];
  endfunction

endpackage

### sv/gpiopi_regs.sv
// ---------------------------------------------------------------------------
// GPIO register file
// Control masks, set/clear decode, read mux and status clear mask.
// ---------------------------------------------------------------------------
`include "gpio_port_with_pin_interrupts_assert.svh"

module gpiopi_regs
  import gpiopi_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  gpio_in_t              item_i,
  input  logic [FieldWidth-1:0] pending_i,
  output irq_ctrl_t             ctrl_o,
  output logic [FieldWidth-1:0] status_clr_o,
  output logic [FieldWidth-1:0] rdata_o,
  output logic [FieldWidth-1:0] out_data_o,
  output logic [FieldWidth-1:0] out_enable_o,
  output logic [FieldWidth-1:0] alt_func_o
);

  localparam logic [FieldWidth-1:0] PinMask = present_pins(PIN_COUNT);

  logic [FieldWidth-1:0] out_data_q, out_data_d;
  logic [FieldWidth-1:0] out_en_q, out_en_d;
  logic [FieldWidth-1:0] alt_q, alt_d;
  logic [FieldWidth-1:0] int_en_q, int_en_d;
  logic [FieldWidth-1:0] int_type_q, int_type_d;
  logic [FieldWidth-1:0] int_pol_q, int_pol_d;
  logic [FieldWidth-1:0] wd, pins, rd;
  logic                  is_wr;

  assign wd    = item_i.wdata & PinMask;
  assign pins  = item_i.pins_in & PinMask;
  assign is_wr = step_i && (item_i.cmd == CMD_WRITE);

  // Write decode
  always_comb begin
    out_data_d = out_data_q;
    out_en_d   = out_en_q;
    alt_d      = alt_q;
    int_en_d   = int_en_q;
    int_type_d = int_type_q;
    int_pol_d  = int_pol_q;
    if (is_wr) begin
      case (item_i.addr)
        REG_DATAOUT:  out_data_d = wd;
        REG_OUTENSET: out_en_d   = out_en_q | wd;
        REG_OUTENCLR: out_en_d   = out_en_q & ~wd;
        REG_ALTSET:   alt_d      = alt_q | wd;
        REG_ALTCLR:   alt_d      = alt_q & ~wd;
        REG_INTENSET: int_en_d   = int_en_q | wd;
        REG_INTENCLR: int_en_d   = int_en_q & ~wd;
        REG_TYPESET:  int_type_d = int_type_q | wd;
        REG_TYPECLR:  int_type_d = int_type_q & ~wd;
        REG_POLSET:   int_pol_d  = int_pol_q | wd;
        REG_POLCLR:   int_pol_d  = int_pol_q & ~wd;
        default: ;
      endcase
    end
  end

  // Read mux, contents from before the word
  always_comb begin
    case (item_i.addr)
      REG_DATA:                   rd = pins;
      REG_DATAOUT:                rd = out_data_q;
      REG_OUTENSET, REG_OUTENCLR: rd = out_en_q;
      REG_ALTSET, REG_ALTCLR:     rd = alt_q;
      REG_INTENSET, REG_INTENCLR: rd = int_en_q;
      REG_TYPESET, REG_TYPECLR:   rd = int_type_q;
      REG_POLSET, REG_POLCLR:     rd = int_pol_q;
      REG_STATUS:                 rd = pending_i;
      default:                    rd = '0;
    endcase
  end

  assign rdata_o      = (item_i.cmd == CMD_READ) ? rd : '0;
  assign status_clr_o = (is_wr && (item_i.addr == REG_STATUS)) ? wd : '0;

  // Detection uses controls from before the word
  assign ctrl_o.enable    = int_en_q;
  assign ctrl_o.edge_type = int_type_q;
  assign ctrl_o.polarity  = int_pol_q;

  assign out_data_o   = out_data_d;
  assign out_enable_o = out_en_d;
  assign alt_func_o   = alt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
      out_en_q   <= '0;
      alt_q      <= '0;
      int_en_q   <= '0;
      int_type_q <= '0;
      int_pol_q  <= '0;
    end else if (step_i) begin
      out_data_q <= out_data_d;
      out_en_q   <= out_en_d;
      alt_q      <= alt_d;
      int_en_q   <= int_en_d;
      int_type_q <= int_type_d;
      int_pol_q  <= int_pol_d;
    end
  end

  // Masks never hold absent pins; nothing changes without a word
  `GPIOPI_ASSERT_IMP(a_regs_masked, clk_i, rst_ni, 1'b1, ((out_en_q | alt_q | int_en_q) & ~PinMask) == '0)
  `GPIOPI_ASSERT_NXT(a_regs_hold, clk_i, rst_ni, !step_i, $stable(out_data_q) && $stable(int_en_q))

endmodule

### sv/gpiopi_irq.sv
// ---------------------------------------------------------------------------
// GPIO interrupt detector
// Edge and level detection per pin, pending status and last pin sample.
// ---------------------------------------------------------------------------
`include "gpio_port_with_pin_interrupts_assert.svh"

module gpiopi_irq
  import gpiopi_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDflt
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [FieldWidth-1:0] pins_i,
  input  irq_ctrl_t             ctrl_i,
  input  logic [FieldWidth-1:0] clr_i,
  output logic [FieldWidth-1:0] pending_q_o,
  output logic [FieldWidth-1:0] pending_d_o
);

  localparam logic [FieldWidth-1:0] PinMask = present_pins(PIN_COUNT);

  logic [FieldWidth-1:0] pending_q, pending_d;
  logic [FieldWidth-1:0] last_q;
  logic [FieldWidth-1:0] pins, rise, fall, edge_hit, level_hit, detect;

  // Detection
  assign pins      = pins_i & PinMask;
  assign rise      = pins & ~last_q;
  assign fall      = ~pins & last_q;
  assign edge_hit  = (rise & ctrl_i.polarity) | (fall & ~ctrl_i.polarity);
  assign level_hit = ~(pins ^ ctrl_i.polarity);
  assign detect    = ((edge_hit & ctrl_i.edge_type) | (level_hit & ~ctrl_i.edge_type))
                     & ctrl_i.enable & PinMask;

  // New detection wins over a same-word clear
  assign pending_d   = step_i ? (((pending_q & ~clr_i) | detect) & PinMask) : pending_q;
  assign pending_q_o = pending_q;
  assign pending_d_o = pending_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      last_q    <= '0;
    end else if (step_i) begin
      pending_q <= pending_d;
      last_q    <= pins;
    end
  end

  `GPIOPI_ASSERT_NXT(a_irq_latch, clk_i, rst_ni, step_i && (detect != '0), pending_q != '0)
  `GPIOPI_ASSERT_NXT(a_irq_hold, clk_i, rst_ni, !step_i, $stable(pending_q) && $stable(last_q))

endmodule

### sv/gpio_port_with_pin_interrupts.sv
// ---------------------------------------------------------------------------
// GPIO port with pin interrupts
// Top level: input register, register file, interrupt detector, result register.
// ---------------------------------------------------------------------------
// One word per clock while the output does not stall: each word (idle tick,
// read or write, with a pad sample) is captured in the input register,
// processed in a single pass through the register file and interrupt
// detector, and its result is taken into the output register when the output
// is free. While a result waits on a stalled output, one more word is taken
// into the input register; only then does the input stall.
`include "gpio_port_with_pin_interrupts_assert.svh"

module gpio_port_with_pin_interrupts
  import gpiopi_pkg::*;
#(
  parameter int PIN_COUNT = PinCountDflt
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gpio_in_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gpio_out_t out_word_o
);

  localparam logic [FieldWidth-1:0] PinMask = present_pins(PIN_COUNT);

  logic      in_valid_q, in_valid_d;
  gpio_in_t  in_q;
  logic      out_valid_q, out_valid_d;
  gpio_out_t out_q, out_d;
  logic      out_free, accept, step;

  irq_ctrl_t             ctrl;
  logic [FieldWidth-1:0] status_clr, pending_q, pending_d;

  // Handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = in_valid_q && !out_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign step        = in_valid_q && out_free;
  assign in_valid_d  = accept || (in_valid_q && !out_free);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  gpiopi_regs #(
    .PIN_COUNT(PIN_COUNT)
  ) u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .item_i       (in_q),
    .pending_i    (pending_q),
    .ctrl_o       (ctrl),
    .status_clr_o (status_clr),
    .rdata_o      (out_d.rdata),
    .out_data_o   (out_d.pins_out),
    .out_enable_o (out_d.pins_drive_enable),
    .alt_func_o   (out_d.alt_select)
  );

  gpiopi_irq #(
    .PIN_COUNT(PIN_COUNT)
  ) u_irq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pins_i      (in_q.pins_in),
    .ctrl_i      (ctrl),
    .clr_i       (status_clr),
    .pending_q_o (pending_q),
    .pending_d_o (pending_d)
  );

  assign out_d.irq = (pending_d != '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (step) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  `GPIOPI_ASSERT_NXT(a_top_keep_in, clk_i, rst_ni, in_valid_q && !out_free, in_valid_q)
  `GPIOPI_ASSERT_NXT(a_top_step_out, clk_i, rst_ni, step, out_valid_q)
  `GPIOPI_ASSERT_IMP(a_top_out_masked, clk_i, rst_ni, out_valid_q, ((out_q.pins_out | out_q.rdata) & ~PinMask) == '0)

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// GPIO port testbench
// Drives idle, read and write words with pad samples into the port, keeps a
// shadow copy of every register and the interrupt latches, and checks each
// result word field by field against the shadow, under random input bursts
// and random output stalls.
// ---------------------------------------------------------------------------
module tb_top;
  import gpiopi_pkg::*;

  localparam int ClkHalf     = 5;
  localparam int ResetCycles = 4;
  localparam int RandomWords = 1000;
  localparam int IdleLimit   = 1000;
  localparam int TailCycles  = 10;

  // Pins that exist in this build
  localparam logic [FieldWidth-1:0] PinsMask =
    {FieldWidth{1'b1}} >> (FieldWidth - PinCountDflt);

  // Codes outside the package enums
  localparam logic [1:0] CmdSpare     = 2'd3;
  localparam logic [3:0] AddrSpareLo  = 4'd2;
  localparam logic [3:0] AddrSpareMid = 4'd3;
  localparam logic [3:0] AddrSpareHi  = 4'd15;

  // Shadow of the port registers plus the queue of results still due
  class gpio_shadow;
    logic [FieldWidth-1:0] out_data, out_enable, alt_function;
    logic [FieldWidth-1:0] int_enable, irq_edge_type, irq_polarity;
    logic [FieldWidth-1:0] irq_pending, last_pins;
    gpio_out_t             due_results[$];
    int                    fails;

    function new();
      out_data      = '0;
      out_enable    = '0;
      alt_function  = '0;
      int_enable    = '0;
      irq_edge_type = '0;
      irq_polarity  = '0;
      irq_pending   = '0;
      last_pins     = '0;
      fails         = 0;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function logic [FieldWidth-1:0] reg_value(logic [3:0] addr, logic [FieldWidth-1:0] pins);
      case (addr)
        REG_DATA:                   return pins;
        REG_DATAOUT:                return out_data;
        REG_OUTENSET, REG_OUTENCLR: return out_enable;
        REG_ALTSET, REG_ALTCLR:     return alt_function;
        REG_INTENSET, REG_INTENCLR: return int_enable;
        REG_TYPESET, REG_TYPECLR:   return irq_edge_type;
        REG_POLSET, REG_POLCLR:     return irq_polarity;
        REG_STATUS:                 return irq_pending;
        default:                    return '0;
      endcase
    endfunction

    // Work out the result of one accepted input word
    function void accept_input(gpio_in_t w);
      logic [FieldWidth-1:0] pins, wd, rise, fall, edge_hit, level_hit, detect;
      gpio_out_t             res;
      pins      = w.pins_in & PinsMask;
      wd        = w.wdata & PinsMask;
      res.rdata = '0;
      if (w.cmd == CMD_READ) res.rdata = reg_value(w.addr, pins) & PinsMask;

      // detection sees the controls from before this word
      rise      = pins & ~last_pins;
      fall      = ~pins & last_pins;
      edge_hit  = (rise & irq_polarity) | (fall & ~irq_polarity);
      level_hit = ~(pins ^ irq_polarity);
      detect    = ((edge_hit & irq_edge_type) | (level_hit & ~irq_edge_type))
                  & int_enable & PinsMask;

      if (w.cmd == CMD_WRITE) begin
        case (w.addr)
          REG_DATAOUT:  out_data = wd;
          REG_OUTENSET: out_enable = out_enable | wd;
          REG_OUTENCLR: out_enable = out_enable & ~wd;
          REG_ALTSET:   alt_function = alt_function | wd;
          REG_ALTCLR:   alt_function = alt_function & ~wd;
          REG_INTENSET: int_enable = int_enable | wd;
          REG_INTENCLR: int_enable = int_enable & ~wd;
          REG_TYPESET:  irq_edge_type = irq_edge_type | wd;
          REG_TYPECLR:  irq_edge_type = irq_edge_type & ~wd;
          REG_POLSET:   irq_polarity = irq_polarity | wd;
          REG_POLCLR:   irq_polarity = irq_polarity & ~wd;
          REG_STATUS:   irq_pending = irq_pending & ~wd;
          default: ;
        endcase
      end

      // new detections win over a clear in the same word
      irq_pending = (irq_pending | detect) & PinsMask;
      last_pins   = pins;

      res.pins_out          = out_data & PinsMask;
      res.pins_drive_enable = out_enable & PinsMask;
      res.alt_select        = alt_function & PinsMask;
      res.irq               = (irq_pending != '0);
      due_results.push_back(res);
    endfunction

    // Compare one accepted result word with the oldest one due
    function void match_result(gpio_out_t got);
      gpio_out_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result word with none due, got %h", $time, got);
        fails++;
        return;
      end
      want = due_results.pop_front();
      if (got.rdata !== want.rdata) begin
        $display("%0t: rdata expected %h actual %h", $time, want.rdata, got.rdata);
        fails++;
      end
      if (got.pins_out !== want.pins_out) begin
        $display("%0t: pins_out expected %h actual %h", $time, want.pins_out, got.pins_out);
        fails++;
      end
      if (got.pins_drive_enable !== want.pins_drive_enable) begin
        $display("%0t: pins_drive_enable expected %h actual %h", $time,
                 want.pins_drive_enable, got.pins_drive_enable);
        fails++;
      end
      if (got.alt_select !== want.alt_select) begin
        $display("%0t: alt_select expected %h actual %h", $time,
                 want.alt_select, got.alt_select);
        fails++;
      end
      if (got.irq !== want.irq) begin
        $display("%0t: irq expected %b actual %b", $time, want.irq, got.irq);
        fails++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  gpio_in_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  gpio_out_t out_word_o;

  gpio_shadow            board = new();
  int                    burst_left = 0;
  int                    idle_cycles = 0;
  logic [FieldWidth-1:0] pin_level = '0;

  gpio_port_with_pin_interrupts #(
    .PIN_COUNT (PinCountDflt)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // Monitor both channels and watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.accept_input(in_word_i);
      if (out_valid_o && !out_stall_i) board.match_result(out_word_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  // Receiver: short free run, one long hold-off, then mixed stretches
  initial begin
    @(posedge rst_ni);
    repeat (30) @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (60) @(posedge clk_i);
    forever begin
      case ($urandom_range(0, 9))
        0: begin
          out_stall_i <= 1'b1;
          repeat ($urandom_range(40, 80)) @(posedge clk_i);
        end
        1, 2, 3: begin
          out_stall_i <= 1'b0;
          repeat ($urandom_range(20, 60)) @(posedge clk_i);
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            out_stall_i <= ($urandom_range(0, 2) == 0);
            @(posedge clk_i);
          end
        end
      endcase
    end
  end

  // Offer one word until taken, then follow the burst pattern
  task feed(input gpio_in_t w);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task feed_fields(input logic [1:0] cmd, input logic [3:0] addr,
                   input logic [FieldWidth-1:0] wdata, input logic [FieldWidth-1:0] pins);
    gpio_in_t w;
    w.cmd     = cmd;
    w.addr    = addr;
    w.wdata   = wdata;
    w.pins_in = pins;
    feed(w);
  endtask

  // Stop offering until every result due has come back
  task drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.outstanding() != 0);
  endtask

  // Mostly sensible register traffic; pads wander a few bits at a time
  function automatic gpio_in_t random_word();
    gpio_in_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      w.cmd = CMD_WRITE;
    else if (pick < 80) w.cmd = CMD_READ;
    else if (pick < 95) w.cmd = CMD_IDLE;
    else                w.cmd = CmdSpare;

    w.addr = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) != 0) begin
      while (w.addr == AddrSpareLo || w.addr == AddrSpareMid || w.addr == AddrSpareHi)
        w.addr = 4'($urandom_range(0, 15));
    end

    case ($urandom_range(0, 3))
      0:       w.wdata = FieldWidth'($urandom);
      1:       w.wdata = 16'd1 << $urandom_range(0, FieldWidth - 1);
      2:       w.wdata = FieldWidth'($urandom & $urandom);
      default: w.wdata = ($urandom_range(0, 1) == 0) ? '0 : '1;
    endcase

    pick = $urandom_range(0, 99);
    if (pick < 70)      pin_level = pin_level ^ FieldWidth'($urandom & $urandom & $urandom);
    else if (pick < 85) pin_level = FieldWidth'($urandom);
    w.pins_in = pin_level;
    return w;
  endfunction

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, every register, spare codes
    feed_fields(CMD_READ,  REG_DATA,     '0,       '1);
    feed_fields(CMD_WRITE, REG_DATAOUT,  '1,       '0);
    feed_fields(CMD_READ,  REG_DATAOUT,  '0,       '0);
    feed_fields(CMD_WRITE, REG_OUTENSET, '1,       '0);
    feed_fields(CMD_WRITE, REG_OUTENCLR, 16'h00ff, '0);
    feed_fields(CMD_READ,  REG_OUTENSET, '0,       '0);
    feed_fields(CMD_READ,  REG_OUTENCLR, '0,       '0);
    feed_fields(CMD_WRITE, REG_ALTSET,   16'haaaa, '0);
    feed_fields(CMD_WRITE, REG_ALTCLR,   16'h000a, '0);
    feed_fields(CMD_READ,  REG_ALTCLR,   '0,       '0);
    // write to DATA is dropped
    feed_fields(CMD_WRITE, REG_DATA,     16'h1234, '0);
    // unknown offsets: writes dropped, reads zero
    feed_fields(CMD_WRITE, AddrSpareLo,  '1,       '0);
    feed_fields(CMD_WRITE, AddrSpareHi,  '1,       '0);
    feed_fields(CMD_READ,  AddrSpareMid, '0,       '0);
    feed_fields(CMD_READ,  AddrSpareHi,  '0,       '0);
    // spare command acts as an idle tick
    feed_fields(CmdSpare,  REG_DATAOUT,  '0,       '0);
    // interrupts: edge on 0-3 and 8-11, level elsewhere, high/rising on 0-7
    feed_fields(CMD_WRITE, REG_POLSET,   16'h00ff, '0);
    feed_fields(CMD_WRITE, REG_TYPESET,  16'h0f0f, '0);
    feed_fields(CMD_WRITE, REG_INTENSET, '1,       '0);
    feed_fields(CMD_IDLE,  REG_DATA,     '0,       '1);
    feed_fields(CMD_IDLE,  REG_DATA,     '0,       '0);
    feed_fields(CMD_READ,  REG_STATUS,   '0,       '0);
    // clear races a level-low detection on the same word
    feed_fields(CMD_WRITE, REG_STATUS,   '1,       '0);
    feed_fields(CMD_READ,  REG_INTENCLR, '0,       '0);
    feed_fields(CMD_WRITE, REG_INTENCLR, '1,       '0);
    feed_fields(CMD_WRITE, REG_TYPECLR,  '1,       '0);
    feed_fields(CMD_WRITE, REG_POLCLR,   16'h00f0, '0);
    feed_fields(CMD_READ,  REG_POLSET,   '0,       '0);
    feed_fields(CMD_WRITE, REG_STATUS,   '1,       '0);
    feed_fields(CMD_READ,  REG_STATUS,   '0,       16'h5a5a);
    pin_level = 16'h5a5a;
    drain();

    // Random traffic, with one full drain partway through
    for (int n = 0; n < RandomWords; n++) begin
      if (n == RandomWords / 2) drain();
      feed(random_word());
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.fails == 0 && board.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
